@@ rtl/core/rpc_pkg.sv @@
package rpc_pkg;

  // Field widths
  localparam int CMD_W    = 1;
  localparam int FLAG_W   = 12;
  localparam int POS_W    = 11;
  localparam int RLEN_W   = 8;
  localparam int CNT_W    = 24;
  localparam int SUM_W    = 26;
  localparam int TOT_W    = 11;
  localparam int MODE_W   = 3;
  localparam int RLENG_W  = 12;
  localparam int RIDX_W   = 2;
  // End address: map_pos + read_length + 2 needs one bit more than the position
  localparam int RAW_W    = 13;

  localparam int DEF_REF_DEPTH = 2048;
  localparam int WINDOW_RADIUS = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // Strand flags
  localparam logic [FLAG_W-1:0] FLAG_PLUS  = 12'd0;
  localparam logic [FLAG_W-1:0] FLAG_MINUS = 12'd16;

  // Counter lanes within a row
  localparam logic [1:0] END_P5 = 2'd0;
  localparam logic [1:0] END_P3 = 2'd1;
  localparam logic [1:0] END_M5 = 2'd2;
  localparam logic [1:0] END_M3 = 2'd3;

  // Sum modes
  localparam logic [MODE_W-1:0] MODE_ALL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIVES   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PLUS    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MINUS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PLUS_P5 = 3'd5;

  // Register indexes
  localparam logic [RIDX_W-1:0] REG_SUM_MODE   = 2'd0;
  localparam logic [RIDX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [RIDX_W-1:0] REG_REF_LENGTH = 2'd2;

  typedef logic [3:0][CNT_W-1:0] cnt_row_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [FLAG_W-1:0] sam_flag;
    logic [POS_W-1:0]  map_pos;
    logic [RLEN_W-1:0] read_length;
    logic [POS_W-1:0]  site_pos;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] echo_pos;
    logic [SUM_W-1:0] selected_sum;
    logic [CNT_W-1:0] plus_five_count;
    logic [CNT_W-1:0] plus_three_count;
    logic [CNT_W-1:0] minus_five_count;
    logic [CNT_W-1:0] minus_three_count;
    logic             is_site;
    logic             near_end;
    logic [TOT_W-1:0] site_total;
    logic [TOT_W-1:0] near_end_total;
    logic             dropped;
  } out_item_t;

  typedef struct packed {
    logic [RIDX_W-1:0] reg_index;
    logic [CNT_W-1:0]  wr_data;
  } cfg_item_t;

endpackage

@@ rtl/core/rpc_chan.sv @@
interface rpc_chan #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rpc_mem.sv @@
module rpc_mem #(
  parameter int DEPTH = rpc_pkg::DEF_REF_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  rpc_pkg::cnt_row_t wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output rpc_pkg::cnt_row_t rdata
);

  rpc_pkg::cnt_row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a write to the same row in that cycle is not seen
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/read_end_pileup_counter.sv @@
// Channel  Dir  Transaction carries                        Handshake
// in_ch    in   cmd, sam_flag, map_pos, read_length,       valid/ready
//               site_pos
// out_ch   out  echo_pos, sums, four counts, flags,        valid/ready
//               totals, dropped
// cfg_ch   in   reg_index, wr_data                         valid/ready, always ready
//
// Each transaction is accepted in IDLE, three work steps follow, and the
// result reaches the output register on the edge that leaves DONE. The row
// memory has one registered read port, and an add runs two read-modify-write
// passes over it (the second read overlaps the first write, with forwarding
// when both ends hit the same row).
// After reset the counter memory is swept to zero, one row a cycle, over all
// REF_DEPTH rows; in_ch is not ready during the sweep, cfg_ch is.
// A finished result waits in the output register while the next transaction
// is accepted; the block holds in its last step only if that register is full.
module read_end_pileup_counter #(
  parameter int REF_DEPTH = rpc_pkg::DEF_REF_DEPTH
) (
  input logic clk,
  input logic rst_n,
  rpc_chan.sink   in_ch,
  rpc_chan.source out_ch,
  rpc_chan.sink   cfg_ch
);

  localparam int AW = $clog2(REF_DEPTH);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_ADD_RD = 9'b000000100,
    S_ADD_A  = 9'b000001000,
    S_ADD_B  = 9'b000010000,
    S_Q_RD   = 9'b000100000,
    S_Q_SUM  = 9'b001000000,
    S_Q_FLAG = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [rpc_pkg::MODE_W-1:0]  sum_mode_r;
  logic [rpc_pkg::CNT_W-1:0]   threshold_r;
  logic [rpc_pkg::RLENG_W-1:0] ref_len_r;

  // Captured transaction and working registers
  rpc_pkg::in_item_t  item_r;
  rpc_pkg::out_item_t res_r;
  rpc_pkg::cnt_row_t  wrow_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [rpc_pkg::SUM_W-1:0] sum_r;
  logic               q_ok_r;
  logic [rpc_pkg::TOT_W-1:0] site_tot_r;
  logic [rpc_pkg::TOT_W-1:0] near_tot_r;

  rpc_pkg::out_item_t out_data_r;
  rpc_pkg::out_item_t out_data_nxt;
  logic               out_valid_r;

  // Memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  rpc_pkg::cnt_row_t mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  rpc_pkg::cnt_row_t mem_rdata;

  rpc_mem #(
    .DEPTH (REF_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Bump one lane of a row, holding at full scale
  function automatic rpc_pkg::cnt_row_t sat_inc(input rpc_pkg::cnt_row_t row,
                                                input logic [1:0] kind);
    rpc_pkg::cnt_row_t r;
    r = row;
    if (r[kind] != rpc_pkg::CNT_MAX) begin
      r[kind] = r[kind] + 1'b1;
    end
    return r;
  endfunction

  // Add addresses: end A is written first, end B second
  logic [rpc_pkg::RAW_W-1:0] a_raw, b_raw;
  logic [1:0]    kind_a, kind_b;
  logic          add_act, a_ok, b_ok, fwd_hit;
  logic [AW-1:0] a_idx, b_idx, q_idx;
  logic          q_ok;

  always_comb begin
    add_act = 1'b1;
    if (item_r.sam_flag == rpc_pkg::FLAG_MINUS) begin
      a_raw  = rpc_pkg::RAW_W'(item_r.map_pos) + rpc_pkg::RAW_W'(item_r.read_length)
             + rpc_pkg::RAW_W'(2);
      b_raw  = rpc_pkg::RAW_W'(item_r.map_pos) + rpc_pkg::RAW_W'(2);
      kind_a = rpc_pkg::END_M5;
      kind_b = rpc_pkg::END_M3;
    end else begin
      a_raw  = rpc_pkg::RAW_W'(item_r.map_pos);
      b_raw  = rpc_pkg::RAW_W'(item_r.map_pos) + rpc_pkg::RAW_W'(item_r.read_length);
      kind_a = rpc_pkg::END_P5;
      kind_b = rpc_pkg::END_P3;
      // Any flag other than the two strands changes nothing
      add_act = (item_r.sam_flag == rpc_pkg::FLAG_PLUS);
    end
    a_ok    = 32'(a_raw) < 32'(REF_DEPTH);
    b_ok    = 32'(b_raw) < 32'(REF_DEPTH);
    a_idx   = AW'(a_raw);
    b_idx   = AW'(b_raw);
    fwd_hit = a_ok && b_ok && (a_raw == b_raw);
    q_ok    = 32'(item_r.site_pos) < 32'(REF_DEPTH);
    q_idx   = AW'(item_r.site_pos);
  end

  // Memory port steering
  rpc_pkg::cnt_row_t row_a_new, row_b_base;

  always_comb begin
    row_a_new  = sat_inc(mem_rdata, kind_a);
    row_b_base = fwd_hit ? wrow_r : mem_rdata;
    mem_we     = 1'b0;
    mem_waddr  = a_idx;
    mem_wdata  = row_a_new;
    mem_re     = 1'b0;
    mem_raddr  = a_idx;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_ADD_RD: begin
        mem_re = add_act && a_ok;
      end
      S_ADD_A: begin
        // Write end A back and read end B in the same cycle
        mem_we    = add_act && a_ok;
        mem_re    = add_act && b_ok;
        mem_raddr = b_idx;
      end
      S_ADD_B: begin
        mem_we    = add_act && b_ok;
        mem_waddr = b_idx;
        mem_wdata = sat_inc(row_b_base, kind_b);
      end
      S_Q_RD: begin
        mem_re    = q_ok;
        mem_raddr = q_idx;
      end
      default: begin
      end
    endcase
  end

  // Query arithmetic
  rpc_pkg::cnt_row_t q_row;
  logic [rpc_pkg::SUM_W-1:0] sum_sel;
  logic in_ref, hit, near_hit, out_load;

  always_comb begin
    q_row = q_ok_r ? mem_rdata : '0;
    case (sum_mode_r)
      rpc_pkg::MODE_ALL: begin
        sum_sel = rpc_pkg::SUM_W'(q_row[rpc_pkg::END_P5])
                + rpc_pkg::SUM_W'(q_row[rpc_pkg::END_P3])
                + rpc_pkg::SUM_W'(q_row[rpc_pkg::END_M5])
                + rpc_pkg::SUM_W'(q_row[rpc_pkg::END_M3]);
      end
      rpc_pkg::MODE_FIVES: begin
        sum_sel = rpc_pkg::SUM_W'(q_row[rpc_pkg::END_P5])
                + rpc_pkg::SUM_W'(q_row[rpc_pkg::END_M5]);
      end
      rpc_pkg::MODE_PLUS: begin
        sum_sel = rpc_pkg::SUM_W'(q_row[rpc_pkg::END_P5])
                + rpc_pkg::SUM_W'(q_row[rpc_pkg::END_P3]);
      end
      rpc_pkg::MODE_MINUS: begin
        sum_sel = rpc_pkg::SUM_W'(q_row[rpc_pkg::END_M5])
                + rpc_pkg::SUM_W'(q_row[rpc_pkg::END_M3]);
      end
      rpc_pkg::MODE_PLUS_P5: begin
        sum_sel = rpc_pkg::SUM_W'(q_row[rpc_pkg::END_P5]);
      end
      default: begin
        sum_sel = '0;
      end
    endcase

    // Position zero and positions past the reference are never sites
    in_ref   = (item_r.site_pos != '0)
            && (rpc_pkg::RLENG_W'(item_r.site_pos) < ref_len_r);
    hit      = in_ref && (sum_r >= rpc_pkg::SUM_W'(threshold_r));
    near_hit = hit && ((item_r.site_pos <= rpc_pkg::POS_W'(rpc_pkg::WINDOW_RADIUS))
            || (rpc_pkg::RAW_W'(item_r.site_pos) + rpc_pkg::RAW_W'(rpc_pkg::WINDOW_RADIUS)
                >= rpc_pkg::RAW_W'(ref_len_r)));
    out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(REF_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.data.cmd == rpc_pkg::CMD_ADD) ? S_ADD_RD : S_Q_RD;
        end
      end
      S_ADD_RD: state_nxt = S_ADD_A;
      S_ADD_A:  state_nxt = S_ADD_B;
      S_ADD_B:  state_nxt = S_DONE;
      S_Q_RD:   state_nxt = S_Q_SUM;
      S_Q_SUM:  state_nxt = S_Q_FLAG;
      S_Q_FLAG: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      site_tot_r  <= '0;
      near_tot_r  <= '0;
      sum_mode_r  <= rpc_pkg::MODE_ALL;
      threshold_r <= rpc_pkg::CNT_W'(1);
      ref_len_r   <= rpc_pkg::RLENG_W'(2048);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // Totals advance only on a site hit, holding at full scale
      if (state_r == S_Q_FLAG && hit) begin
        if (site_tot_r != rpc_pkg::TOT_MAX) begin
          site_tot_r <= site_tot_r + 1'b1;
        end
        if (near_hit && near_tot_r != rpc_pkg::TOT_MAX) begin
          near_tot_r <= near_tot_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.data.reg_index)
          rpc_pkg::REG_SUM_MODE:   sum_mode_r  <= cfg_ch.data.wr_data[rpc_pkg::MODE_W-1:0];
          rpc_pkg::REG_THRESHOLD:  threshold_r <= cfg_ch.data.wr_data;
          rpc_pkg::REG_REF_LENGTH: ref_len_r   <= cfg_ch.data.wr_data[rpc_pkg::RLENG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Totals fields of res_r are placeholders; the live totals go in at load time
  always_comb begin
    out_data_nxt                = res_r;
    out_data_nxt.site_total     = site_tot_r;
    out_data_nxt.near_end_total = near_tot_r;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      item_r <= in_ch.data;
    end
    if (state_r == S_ADD_A) begin
      wrow_r <= row_a_new;
    end
    if (state_r == S_Q_SUM) begin
      sum_r                   <= sum_sel;
      res_r.echo_pos          <= item_r.site_pos;
      res_r.plus_five_count   <= q_row[rpc_pkg::END_P5];
      res_r.plus_three_count  <= q_row[rpc_pkg::END_P3];
      res_r.minus_five_count  <= q_row[rpc_pkg::END_M5];
      res_r.minus_three_count <= q_row[rpc_pkg::END_M3];
    end
    if (state_r == S_Q_RD) begin
      q_ok_r <= q_ok;
    end
    if (state_r == S_Q_FLAG) begin
      res_r.selected_sum   <= sum_r;
      res_r.is_site        <= hit;
      res_r.near_end       <= near_hit;
      res_r.site_total     <= '0;
      res_r.near_end_total <= '0;
      res_r.dropped        <= 1'b0;
    end
    if (state_r == S_ADD_B) begin
      res_r.echo_pos          <= item_r.map_pos;
      res_r.selected_sum      <= '0;
      res_r.plus_five_count   <= '0;
      res_r.plus_three_count  <= '0;
      res_r.minus_five_count  <= '0;
      res_r.minus_three_count <= '0;
      res_r.is_site           <= 1'b0;
      res_r.near_end          <= 1'b0;
      res_r.site_total        <= '0;
      res_r.near_end_total    <= '0;
      res_r.dropped           <= add_act && (!a_ok || !b_ok);
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Near-end hits are a subset of site hits
  a_near_le_site: assert property (@(posedge clk) disable iff (!rst_n)
    near_tot_r <= site_tot_r)
    else $error("near-end total exceeds site total");

  // The site total never falls outside reset
  a_tot_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> site_tot_r >= $past(site_tot_r))
    else $error("site total decreased");

  // A forwarded end B row must come from the end A write just before
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_B && add_act && fwd_hit) |-> ($past(mem_we) && $past(mem_waddr) == b_idx))
    else $error("forwarded row has no matching write");

endmodule
